>>> hdl/kvct_pkg.sv
// Shared types and constants for the key/value count table.
`default_nettype none

package kvct_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int WORD_W      = 32;
	localparam int TOTAL_W     = 9;

	typedef logic [1:0]        opcode_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam opcode_t OP_SET = 2'd0;
	localparam opcode_t OP_INC = 2'd1;
	localparam opcode_t OP_GET = 2'd2;

	localparam word_t VALUE_MAX    = 32'h7FFF_FFFF;
	localparam word_t ABSENT_VALUE = 32'hFFFF_FFFF;
	localparam word_t VALUE_ONE    = 32'h0000_0001;

endpackage

`default_nettype wire

>>> hdl/key_value_count_table.sv
// Key/value table with linear search: set, increment and get over stored keys.
//
// Each item is a command (start while busy is low). The table is searched from
// the oldest entry, one key memory read per cycle, so the search of N stored
// entries dominates the time a command takes; increment or get on a hit adds a
// value memory read in the S_VALUE state. The result appears for one cycle
// with done high, in the cycle busy falls; the receiver cannot stall it, and a
// new command may be issued in that same cycle. Memories need no clearing
// after reset: only entries below the stored count are ever read.
`default_nettype none

module key_value_count_table
	import kvct_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                opcode,
	input  wire logic signed [WORD_W-1:0]  key,
	input  wire logic signed [WORD_W-1:0]  value,
	output logic                           done,
	output logic                           found,
	output logic signed [WORD_W-1:0]       read_value,
	output logic                           status,
	output logic [TOTAL_W-1:0]             entry_total
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_VALUE
	} state_t;

	state_t            state_q;
	opcode_t           op_q;
	word_t             key_q;
	word_t             value_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  iss_q;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s1;
	logic [IDX_W-1:0]  slot_q;
	word_t             key_rd_s1;
	word_t             val_rd_s1;

	logic              done_q;
	logic              found_q;
	word_t             read_value_q;
	logic              status_q;
	logic [TOTAL_W-1:0] total_q;

	word_t key_mem [ENTRIES];
	word_t val_mem [ENTRIES];

	logic              issue;
	logic              match;
	logic              miss;
	logic              upd;
	logic              room;
	logic              key_we;
	logic              val_we;
	logic [IDX_W-1:0]  val_waddr;
	word_t             val_wdata;
	word_t             inc_value;

	always_comb begin
		issue     = (state_q == S_SEARCH) && (iss_q < count_q);
		match     = vld_s1 && (key_rd_s1 == key_q);
		miss      = !match && (iss_q == count_q);
		upd       = (op_q == OP_SET) || (op_q == OP_INC);
		room      = count_q < CNT_FULL;
		inc_value = (val_rd_s1 == VALUE_MAX) ? val_rd_s1 : val_rd_s1 + VALUE_ONE;
		key_we    = 1'b0;
		val_we    = 1'b0;
		val_waddr = idx_s1;
		val_wdata = value_q;
		unique case (state_q)
			S_SEARCH: begin
				if (match) begin
					val_we = (op_q == OP_SET);
				end else if (miss && upd && room) begin
					key_we    = 1'b1;
					val_we    = 1'b1;
					val_waddr = count_q[IDX_W-1:0];
					val_wdata = (op_q == OP_SET) ? value_q : VALUE_ONE;
				end
			end
			S_VALUE: begin
				val_we    = (op_q == OP_INC);
				val_waddr = slot_q;
				val_wdata = inc_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[count_q[IDX_W-1:0]] <= key_q;
		key_rd_s1 <= key_mem[iss_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (val_we)
			val_mem[val_waddr] <= val_wdata;
		val_rd_s1 <= val_mem[idx_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			iss_q    <= '0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			status_q <= 1'b0;
			total_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (start) begin
						op_q    <= opcode;
						key_q   <= key;
						value_q <= value;
						iss_q   <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					vld_s1 <= issue;
					idx_s1 <= iss_q[IDX_W-1:0];
					if (issue)
						iss_q <= iss_q + 1'b1;
					if (match) begin
						slot_q <= idx_s1;
						vld_s1 <= 1'b0;
						if (op_q == OP_SET) begin
							done_q       <= 1'b1;
							found_q      <= 1'b1;
							read_value_q <= value_q;
							status_q     <= 1'b0;
							total_q      <= TOTAL_W'(count_q);
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_VALUE;
						end
					end else if (miss) begin
						done_q  <= 1'b1;
						found_q <= 1'b0;
						state_q <= S_IDLE;
						if (upd && room) begin
							read_value_q <= (op_q == OP_SET) ? value_q : VALUE_ONE;
							status_q     <= 1'b0;
							count_q      <= count_q + 1'b1;
							total_q      <= TOTAL_W'(count_q + 1'b1);
						end else begin
							read_value_q <= ABSENT_VALUE;
							status_q     <= upd;
							total_q      <= TOTAL_W'(count_q);
						end
					end
				end
				S_VALUE: begin
					done_q       <= 1'b1;
					found_q      <= 1'b1;
					read_value_q <= (op_q == OP_INC) ? inc_value : val_rd_s1;
					status_q     <= 1'b0;
					total_q      <= TOTAL_W'(count_q);
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_total = total_q;

endmodule

`default_nettype wire
